[hdl/rjit_pkg.sv]
// shared widths, reset values, register indexes and the xorshift step
// for the random jitter interval timer; no dependencies
package rjit_pkg;

    localparam int WORD_W  = 32;
    localparam int DELTA_W = 7;
    localparam int SPAN_W  = DELTA_W + 1;
    localparam int STEP_W  = 8;
    localparam int CNT_W   = $clog2(WORD_W);
    localparam int IDX_W   = 3;

    localparam logic [WORD_W-1:0]  SEED_DEFAULT     = 32'h1234_5678;
    localparam logic [DELTA_W-1:0] MAX_DELTA_RST    = 7'd1;
    localparam logic [WORD_W-1:0]  MOTION_INT_RST   = 32'd1000;
    localparam logic [WORD_W-1:0]  CLICK_INT_RST    = 32'd60000;

    localparam logic [IDX_W-1:0] REG_MAX_DELTA     = 3'd0;
    localparam logic [IDX_W-1:0] REG_MOTION_INT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CLICK_INT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_SEED          = 3'd3;
    localparam logic [IDX_W-1:0] REG_MOTION_ENABLE = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLICK_ENABLE  = 3'd5;

    localparam logic MODE_TICK     = 1'b0;
    localparam logic MODE_REANCHOR = 1'b1;

    typedef struct packed {
        logic                 done;
        logic [SPAN_W-1:0]    rem;
    } mod_status_t;

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] x_in);
        logic [WORD_W-1:0] x;
        x = x_in;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

[hdl/rjit_mod_serial.sv]
// bit-serial restoring remainder of a 32-bit word by an 8-bit span
// uses rjit_pkg for widths and the status struct
module rjit_mod_serial
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rjit_pkg::WORD_W-1:0]       dividend,
    input  logic [rjit_pkg::SPAN_W-1:0]       span,
    output rjit_pkg::mod_status_t             status
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rjit_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [rjit_pkg::WORD_W-1:0]      sh_reg, sh_next;
    logic [rjit_pkg::SPAN_W-1:0]      rem_reg, rem_next;
    logic [rjit_pkg::SPAN_W:0]        trial;

    localparam logic [rjit_pkg::CNT_W-1:0] CNT_LAST =
        rjit_pkg::CNT_W'(rjit_pkg::WORD_W - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, sh_reg[rjit_pkg::WORD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // one dividend bit per cycle, msb first
            if (trial >= {1'b0, span})
            begin
                rem_next = rjit_pkg::SPAN_W'(trial - {1'b0, span});
            end
            else
            begin
                rem_next = trial[rjit_pkg::SPAN_W-1:0];
            end
            sh_next  = sh_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.rem  = rem_reg;

endmodule

[hdl/random_jitter_interval_timer.sv]
// top level: two wrapping millisecond interval timers with xorshift32 jitter steps
// uses rjit_pkg and rjit_mod_serial
// flow: an accepted word is registered, evaluated in S_EVAL and presented from S_RESULT;
// when motion fires, two bit-serial remainders run first, one per axis (S_DX, S_DY)
// in_stall holds off a new word until the current one has gone to the output register
// reset: async active low; control/config registers take their reset values, seed 0x12345678
module random_jitter_interval_timer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic [rjit_pkg::WORD_W-1:0]          now_ms,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 motion_fire,
    output logic signed [rjit_pkg::STEP_W-1:0]   delta_x,
    output logic signed [rjit_pkg::STEP_W-1:0]   delta_y,
    output logic                                 click_fire,
    output logic [rjit_pkg::WORD_W-1:0]          wait_ms,
    input  logic                                 cfg_we,
    input  logic [rjit_pkg::IDX_W-1:0]           cfg_index,
    input  logic [rjit_pkg::WORD_W-1:0]          cfg_data
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_EVAL,
        S_DX,
        S_DX_WAIT,
        S_DY,
        S_DY_WAIT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    logic [rjit_pkg::DELTA_W-1:0] max_delta_reg, max_delta_next;
    logic [rjit_pkg::WORD_W-1:0]  motion_int_reg, motion_int_next;
    logic [rjit_pkg::WORD_W-1:0]  click_int_reg, click_int_next;
    logic                         motion_en_reg, motion_en_next;
    logic                         click_en_reg, click_en_next;

    logic [rjit_pkg::WORD_W-1:0]  rng_reg, rng_next;
    logic [rjit_pkg::WORD_W-1:0]  last_motion_reg, last_motion_next;
    logic                         motion_anch_reg, motion_anch_next;
    logic [rjit_pkg::WORD_W-1:0]  last_click_reg, last_click_next;
    logic                         click_anch_reg, click_anch_next;

    logic                         mode_reg, mode_next;
    logic [rjit_pkg::WORD_W-1:0]  now_reg, now_next;
    logic                         mfire_reg, mfire_next;
    logic                         cfire_reg, cfire_next;
    logic [rjit_pkg::SPAN_W-1:0]  rem_x_reg, rem_x_next;
    logic [rjit_pkg::SPAN_W-1:0]  rem_y_reg, rem_y_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_mfire_reg, out_mfire_next;
    logic [rjit_pkg::STEP_W-1:0]  out_dx_reg, out_dx_next;
    logic [rjit_pkg::STEP_W-1:0]  out_dy_reg, out_dy_next;
    logic                         out_cfire_reg, out_cfire_next;
    logic [rjit_pkg::WORD_W-1:0]  out_wait_reg, out_wait_next;

    logic [rjit_pkg::DELTA_W-1:0] md_eff;
    logic [rjit_pkg::SPAN_W-1:0]  span;
    logic [rjit_pkg::STEP_W-1:0]  md_step;
    logic [rjit_pkg::WORD_W-1:0]  motion_elapsed;
    logic [rjit_pkg::WORD_W-1:0]  click_elapsed;
    logic                         out_free;
    logic                         div_start;
    rjit_pkg::mod_status_t        div_status;

    assign md_eff   = (max_delta_reg == '0) ? rjit_pkg::DELTA_W'(1) : max_delta_reg;
    assign span     = {md_eff, 1'b1};
    assign md_step  = rjit_pkg::STEP_W'(md_eff);
    assign motion_elapsed = now_reg - last_motion_reg;
    assign click_elapsed  = now_reg - last_click_reg;
    assign out_free = !out_valid_reg || !out_stall;

    rjit_mod_serial u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rng_reg),
        .span     (span),
        .status   (div_status)
    );

    always_comb
    begin
        state_next       = state_reg;
        max_delta_next   = max_delta_reg;
        motion_int_next  = motion_int_reg;
        click_int_next   = click_int_reg;
        motion_en_next   = motion_en_reg;
        click_en_next    = click_en_reg;
        rng_next         = rng_reg;
        last_motion_next = last_motion_reg;
        motion_anch_next = motion_anch_reg;
        last_click_next  = last_click_reg;
        click_anch_next  = click_anch_reg;
        mode_next        = mode_reg;
        now_next         = now_reg;
        mfire_next       = mfire_reg;
        cfire_next       = cfire_reg;
        rem_x_next       = rem_x_reg;
        rem_y_next       = rem_y_reg;
        out_valid_next   = out_valid_reg;
        out_mfire_next   = out_mfire_reg;
        out_dx_next      = out_dx_reg;
        out_dy_next      = out_dy_reg;
        out_cfire_next   = out_cfire_reg;
        out_wait_next    = out_wait_reg;
        div_start        = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    now_next   = now_ms;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                mfire_next = 1'b0;
                cfire_next = 1'b0;
                state_next = S_RESULT;
                if (mode_reg == rjit_pkg::MODE_REANCHOR)
                begin
                    last_motion_next = now_reg;
                    motion_anch_next = 1'b1;
                end
                else
                begin
                    // an unanchored motion timer fires at once; the click timer only anchors
                    if (motion_en_reg &&
                        (!motion_anch_reg || motion_elapsed >= motion_int_reg))
                    begin
                        last_motion_next = now_reg;
                        motion_anch_next = 1'b1;
                        mfire_next       = 1'b1;
                        rng_next         = rjit_pkg::xorshift(rng_reg);
                        state_next       = S_DX;
                    end
                    if (click_en_reg)
                    begin
                        if (!click_anch_reg)
                        begin
                            last_click_next = now_reg;
                            click_anch_next = 1'b1;
                        end
                        else if (click_elapsed >= click_int_reg)
                        begin
                            last_click_next = now_reg;
                            cfire_next      = 1'b1;
                        end
                    end
                end
            end
            S_DX:
            begin
                div_start  = 1'b1;
                state_next = S_DX_WAIT;
            end
            S_DX_WAIT:
            begin
                if (div_status.done)
                begin
                    rem_x_next = div_status.rem;
                    rng_next   = rjit_pkg::xorshift(rng_reg);
                    state_next = S_DY;
                end
            end
            S_DY:
            begin
                div_start  = 1'b1;
                state_next = S_DY_WAIT;
            end
            S_DY_WAIT:
            begin
                if (div_status.done)
                begin
                    rem_y_next = div_status.rem;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mfire_next = mfire_reg;
                    out_cfire_next = cfire_reg;
                    if (mfire_reg)
                    begin
                        // both steps zero: x takes the full step
                        if (rem_x_reg == md_step && rem_y_reg == md_step)
                        begin
                            out_dx_next = md_step;
                        end
                        else
                        begin
                            out_dx_next = rem_x_reg - md_step;
                        end
                        out_dy_next = rem_y_reg - md_step;
                    end
                    else
                    begin
                        out_dx_next = '0;
                        out_dy_next = '0;
                    end
                    if (!motion_en_reg || !motion_anch_reg ||
                        motion_elapsed >= motion_int_reg)
                    begin
                        out_wait_next = '0;
                    end
                    else
                    begin
                        out_wait_next = motion_int_reg - motion_elapsed;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                rjit_pkg::REG_MAX_DELTA:
                begin
                    max_delta_next = cfg_data[rjit_pkg::DELTA_W-1:0];
                end
                rjit_pkg::REG_MOTION_INT:
                begin
                    motion_int_next = cfg_data;
                end
                rjit_pkg::REG_CLICK_INT:
                begin
                    click_int_next = cfg_data;
                end
                rjit_pkg::REG_SEED:
                begin
                    rng_next = (cfg_data == '0) ? rjit_pkg::SEED_DEFAULT : cfg_data;
                end
                rjit_pkg::REG_MOTION_ENABLE:
                begin
                    motion_en_next   = cfg_data[0];
                    motion_anch_next = 1'b0;
                end
                rjit_pkg::REG_CLICK_ENABLE:
                begin
                    click_en_next   = cfg_data[0];
                    click_anch_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_delta_reg   <= rjit_pkg::MAX_DELTA_RST;
            motion_int_reg  <= rjit_pkg::MOTION_INT_RST;
            click_int_reg   <= rjit_pkg::CLICK_INT_RST;
            motion_en_reg   <= 1'b0;
            click_en_reg    <= 1'b0;
            rng_reg         <= rjit_pkg::SEED_DEFAULT;
            last_motion_reg <= '0;
            motion_anch_reg <= 1'b0;
            last_click_reg  <= '0;
            click_anch_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_delta_reg   <= max_delta_next;
            motion_int_reg  <= motion_int_next;
            click_int_reg   <= click_int_next;
            motion_en_reg   <= motion_en_next;
            click_en_reg    <= click_en_next;
            rng_reg         <= rng_next;
            last_motion_reg <= last_motion_next;
            motion_anch_reg <= motion_anch_next;
            last_click_reg  <= last_click_next;
            click_anch_reg  <= click_anch_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        now_reg       <= now_next;
        mfire_reg     <= mfire_next;
        cfire_reg     <= cfire_next;
        rem_x_reg     <= rem_x_next;
        rem_y_reg     <= rem_y_next;
        out_mfire_reg <= out_mfire_next;
        out_dx_reg    <= out_dx_next;
        out_dy_reg    <= out_dy_next;
        out_cfire_reg <= out_cfire_next;
        out_wait_reg  <= out_wait_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign motion_fire = out_mfire_reg;
    assign delta_x     = out_dx_reg;
    assign delta_y     = out_dy_reg;
    assign click_fire  = out_cfire_reg;
    assign wait_ms     = out_wait_reg;

endmodule
